// ===== src/assert_macros.svh =====
// Assertion macros shared by the ray/box nearest-hit RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RBNH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define RBNH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rbnh_pkg.sv =====
// Package for the ray/box nearest-hit unit: widths, register indexes,
// reset values and the divider status type. No dependencies.
`default_nettype none

package rbnh_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int ENTITY_WIDTH = 16;

  // Direction components are signed Q1.14
  localparam int DIR_WIDTH = 16;
  localparam int DIR_FRAC  = 14;

  localparam int CFG_IDX_WIDTH = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_DIR_X      = 3'd2,
    CFG_DIR_Y      = 3'd3,
    CFG_RAY_LENGTH = 3'd4
  } cfg_idx_t;

  localparam logic [DIR_WIDTH-1:0] DIR_X_RST   = 16'd16384;
  localparam logic [DIR_WIDTH-1:0] DIR_Y_RST   = 16'd0;
  localparam logic [31:0]          RAY_LEN_RST = 32'd128000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

// ===== src/rbnh_box_if.sv =====
// Box input channel: valid/ready handshake with the box payload.
// Depends on rbnh_pkg for default widths.
`default_nettype none

interface rbnh_box_if #(
  parameter int COORD_WIDTH  = rbnh_pkg::COORD_WIDTH,
  parameter int ENTITY_WIDTH = rbnh_pkg::ENTITY_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_WIDTH-1:0]  box_min_x;
  logic signed [COORD_WIDTH-1:0]  box_min_y;
  logic signed [COORD_WIDTH-1:0]  box_max_x;
  logic signed [COORD_WIDTH-1:0]  box_max_y;
  logic        [ENTITY_WIDTH-1:0] entity_id;
  logic                           last_box;

  modport source (
    output valid, box_min_x, box_min_y, box_max_x, box_max_y, entity_id, last_box,
    input  ready
  );

  modport sink (
    input  valid, box_min_x, box_min_y, box_max_x, box_max_y, entity_id, last_box,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/rbnh_hit_if.sv =====
// Result channel: valid/ready handshake with hit flag, distance and entity.
// Depends on rbnh_pkg for default widths.
`default_nettype none

interface rbnh_hit_if #(
  parameter int COORD_WIDTH  = rbnh_pkg::COORD_WIDTH,
  parameter int ENTITY_WIDTH = rbnh_pkg::ENTITY_WIDTH
);
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [COORD_WIDTH-2:0]  hit_distance;
  logic [ENTITY_WIDTH-1:0] hit_entity;

  modport source (
    output valid, hit, hit_distance, hit_entity,
    input  ready
  );

  modport sink (
    input  valid, hit, hit_distance, hit_entity,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/rbnh_div.sv =====
// Shared serial divider: restoring division, one quotient bit per cycle,
// signed result truncated toward zero and saturated. Depends on rbnh_pkg.
`default_nettype none

module rbnh_div #(
  parameter int COORD_WIDTH = rbnh_pkg::COORD_WIDTH
) (
  input  wire logic                                               clk,
  input  wire logic                                               rst_n,
  input  wire logic                                               start,
  input  wire logic [COORD_WIDTH+rbnh_pkg::DIR_FRAC:0]            num_mag,
  input  wire logic [rbnh_pkg::DIR_WIDTH-1:0]                     den_mag,
  input  wire logic                                               neg,
  output rbnh_pkg::div_sts_t                                      sts,
  output logic signed [COORD_WIDTH-1:0]                           quot
);

  localparam int NW    = COORD_WIDTH + rbnh_pkg::DIR_FRAC + 1;
  localparam int DW    = rbnh_pkg::DIR_WIDTH;
  localparam int QW    = COORD_WIDTH - 1;
  localparam int CNT_W = $clog2(QW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [DW-1:0]    rem_r,  rem_nxt;
  logic [QW-1:0]    lo_r,   lo_nxt;
  logic [QW-1:0]    q_r,    q_nxt;
  logic [DW-1:0]    den_r,  den_nxt;
  logic             neg_r,  neg_nxt;
  logic             sat_r,  sat_nxt;

  logic [DW-1:0]    num_hi;
  logic             start_sat;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;
  logic [COORD_WIDTH-1:0] mag;

  // Quotient overflows the result range when the top bits already reach the divisor
  assign num_hi    = num_mag[NW-1 -: DW];
  assign start_sat = (num_hi >= den_mag);

  assign trial = {rem_r, lo_r[QW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    sat_nxt  = sat_r;
    if (start) begin
      den_nxt = den_mag;
      neg_nxt = neg;
      sat_nxt = start_sat;
      rem_nxt = num_hi;
      lo_nxt  = num_mag[QW-1:0];
      q_nxt   = '0;
      cnt_nxt = CNT_W'(QW - 1);
      if (start_sat) begin
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      lo_nxt  = {lo_r[QW-2:0], 1'b0};
      q_nxt   = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    sat_r <= sat_nxt;
  end

  assign mag = {1'b0, q_r};

  always_comb begin
    if (sat_r) begin
      quot = neg_r ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
    end else begin
      quot = neg_r ? (~mag + 1'b1) : mag;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

// ===== src/rbnh_seq.sv =====
// Sequencer for the slab test: walks both axes of one box through the
// shared divider, keeps the nearest hit and emits the stream result. Uses rbnh_pkg.
`default_nettype none

module rbnh_seq #(
  parameter int COORD_WIDTH  = rbnh_pkg::COORD_WIDTH,
  parameter int ENTITY_WIDTH = rbnh_pkg::ENTITY_WIDTH
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // box transfer
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]           box_min_x,
  input  wire logic signed [COORD_WIDTH-1:0]           box_min_y,
  input  wire logic signed [COORD_WIDTH-1:0]           box_max_x,
  input  wire logic signed [COORD_WIDTH-1:0]           box_max_y,
  input  wire logic        [ENTITY_WIDTH-1:0]          entity_id,
  input  wire logic                                    last_box,
  // ray set-up
  input  wire logic signed [COORD_WIDTH-1:0]           origin_x,
  input  wire logic signed [COORD_WIDTH-1:0]           origin_y,
  input  wire logic        [rbnh_pkg::DIR_WIDTH-1:0]   dir_x,
  input  wire logic        [rbnh_pkg::DIR_WIDTH-1:0]   dir_y,
  input  wire logic        [COORD_WIDTH-2:0]           ray_length,
  // result toward the output register
  input  wire logic                                    slot_free,
  output logic                                         res_valid,
  output logic                                         res_hit,
  output logic             [COORD_WIDTH-2:0]           res_distance,
  output logic             [ENTITY_WIDTH-1:0]          res_entity,
  // shared divider
  output logic                                         div_start,
  output logic [COORD_WIDTH+rbnh_pkg::DIR_FRAC:0]      div_num,
  output logic [rbnh_pkg::DIR_WIDTH-1:0]               div_den,
  output logic                                         div_neg,
  input  wire rbnh_pkg::div_sts_t                      div_sts,
  input  wire logic signed [COORD_WIDTH-1:0]           div_quot
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = rbnh_pkg::DIR_WIDTH;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SETUP  = 8'b0000_0010,
    ST_DIV_LO = 8'b0000_0100,
    ST_DIV_HI = 8'b0000_1000,
    ST_SLAB   = 8'b0001_0000,
    ST_CHECK  = 8'b0010_0000,
    ST_BEST   = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  logic       axis_r,  axis_nxt;
  logic       any_hit_r, any_hit_nxt;

  logic signed [CW-1:0]           minx_r, minx_nxt;
  logic signed [CW-1:0]           miny_r, miny_nxt;
  logic signed [CW-1:0]           maxx_r, maxx_nxt;
  logic signed [CW-1:0]           maxy_r, maxy_nxt;
  logic        [ENTITY_WIDTH-1:0] ent_r,  ent_nxt;
  logic                           last_r, last_nxt;
  logic signed [CW-1:0]           tmin_r, tmin_nxt;
  logic signed [CW-1:0]           tmax_r, tmax_nxt;
  logic signed [CW-1:0]           t1_r,   t1_nxt;
  logic signed [CW-1:0]           t2_r,   t2_nxt;
  logic                           hit_r,  hit_nxt;
  logic        [CW-2:0]           best_dist_r, best_dist_nxt;
  logic        [ENTITY_WIDTH-1:0] best_ent_r,  best_ent_nxt;

  logic signed [CW-1:0] org_sel, lo_sel, hi_sel, bound_sel;
  logic        [DW-1:0] dir_sel;
  logic                 dir_zero;
  logic        [CW:0]   dsub;
  logic        [CW:0]   d_mag;
  logic signed [CW-1:0] t_near, t_far;
  logic        [CW-2:0] best_cur;

  // Per-axis operand selection
  assign org_sel   = axis_r ? origin_y : origin_x;
  assign dir_sel   = axis_r ? dir_y    : dir_x;
  assign lo_sel    = axis_r ? miny_r   : minx_r;
  assign hi_sel    = axis_r ? maxy_r   : maxx_r;
  assign dir_zero  = (dir_sel == '0);
  assign bound_sel = (state_r == ST_DIV_LO) ? hi_sel : lo_sel;

  // Numerator magnitude (bound - origin) * 2^frac, sign carried separately
  assign dsub    = {bound_sel[CW-1], bound_sel} - {org_sel[CW-1], org_sel};
  assign d_mag   = dsub[CW] ? (~dsub + 1'b1) : dsub;
  assign div_num = {d_mag, {rbnh_pkg::DIR_FRAC{1'b0}}};
  assign div_den = dir_sel[DW-1] ? (~dir_sel + 1'b1) : dir_sel;
  assign div_neg = dsub[CW] ^ dir_sel[DW-1];

  assign t_near   = (t1_r > t2_r) ? t2_r : t1_r;
  assign t_far    = (t1_r > t2_r) ? t1_r : t2_r;
  assign best_cur = any_hit_r ? best_dist_r : ray_length;

  assign in_ready     = (state_r == ST_IDLE);
  assign res_hit      = any_hit_r;
  assign res_distance = any_hit_r ? best_dist_r : ray_length;
  assign res_entity   = any_hit_r ? best_ent_r : {ENTITY_WIDTH{1'b1}};

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    any_hit_nxt   = any_hit_r;
    minx_nxt      = minx_r;
    miny_nxt      = miny_r;
    maxx_nxt      = maxx_r;
    maxy_nxt      = maxy_r;
    ent_nxt       = ent_r;
    last_nxt      = last_r;
    tmin_nxt      = tmin_r;
    tmax_nxt      = tmax_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    hit_nxt       = hit_r;
    best_dist_nxt = best_dist_r;
    best_ent_nxt  = best_ent_r;
    div_start     = 1'b0;
    res_valid     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          minx_nxt  = box_min_x;
          miny_nxt  = box_min_y;
          maxx_nxt  = box_max_x;
          maxy_nxt  = box_max_y;
          ent_nxt   = entity_id;
          last_nxt  = last_box;
          axis_nxt  = 1'b0;
          tmin_nxt  = '0;
          tmax_nxt  = {1'b0, ray_length};
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (dir_zero) begin
          // Parallel to this axis: origin must lie inside the slab
          if ((org_sel < lo_sel) || (org_sel > hi_sel)) begin
            hit_nxt   = 1'b0;
            state_nxt = ST_BEST;
          end else if (!axis_r) begin
            axis_nxt  = 1'b1;
          end else begin
            hit_nxt   = 1'b1;
            state_nxt = ST_BEST;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_LO;
        end
      end
      ST_DIV_LO: begin
        if (div_sts.done) begin
          t1_nxt    = div_quot;
          div_start = 1'b1;
          state_nxt = ST_DIV_HI;
        end
      end
      ST_DIV_HI: begin
        if (div_sts.done) begin
          t2_nxt    = div_quot;
          state_nxt = ST_SLAB;
        end
      end
      ST_SLAB: begin
        tmin_nxt  = (t_near > tmin_r) ? t_near : tmin_r;
        tmax_nxt  = (t_far < tmax_r) ? t_far : tmax_r;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (tmin_r > tmax_r) begin
          hit_nxt   = 1'b0;
          state_nxt = ST_BEST;
        end else if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = ST_SETUP;
        end else begin
          hit_nxt   = 1'b1;
          state_nxt = ST_BEST;
        end
      end
      ST_BEST: begin
        // Entry distance is never negative here; ties keep the older hit
        if (hit_r && (tmin_r[CW-2:0] < best_cur)) begin
          best_dist_nxt = tmin_r[CW-2:0];
          best_ent_nxt  = ent_r;
          any_hit_nxt   = 1'b1;
        end
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free) begin
          res_valid   = 1'b1;
          any_hit_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      axis_r    <= 1'b0;
      any_hit_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      axis_r    <= axis_nxt;
      any_hit_r <= any_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    minx_r      <= minx_nxt;
    miny_r      <= miny_nxt;
    maxx_r      <= maxx_nxt;
    maxy_r      <= maxy_nxt;
    ent_r       <= ent_nxt;
    last_r      <= last_nxt;
    tmin_r      <= tmin_nxt;
    tmax_r      <= tmax_nxt;
    t1_r        <= t1_nxt;
    t2_r        <= t2_nxt;
    hit_r       <= hit_nxt;
    best_dist_r <= best_dist_nxt;
    best_ent_r  <= best_ent_nxt;
  end

endmodule

`default_nettype wire

// ===== src/ray_box_nearest_hit_2d_unit.sv =====
// Top level of the 2D ray versus axis-aligned box nearest-hit unit.
// Depends on rbnh_pkg, rbnh_box_if, rbnh_hit_if, rbnh_div, rbnh_seq, assert_macros.svh.
//
// Program the ray (origin, direction, length) through the cfg_ write port while the
// unit is idle, then stream boxes in; each box gets the slab test on X and then Y and
// the nearest entry distance strictly below the running best (starting at the ray
// length) is kept together with its entity. The box flagged last_box ends the stream:
// one result transfer follows with hit, hit_distance (ray length on a miss) and
// hit_entity (all ones on a miss), and the running best is cleared. Positions and
// distances are signed Q15.8, directions Q1.14; slab distances are truncated toward
// zero and saturated to the coordinate range. The unit takes one box at a time, and the
// single shared serial divider runs up to four divisions per box (two per axis): an
// axis whose direction component is zero needs no division, a saturating quotient skips
// the serial steps, and a box missed on X skips Y. A finished result sits in an output
// register, so the next box is taken while the result still waits for the sink.
`default_nettype none

`include "assert_macros.svh"

module ray_box_nearest_hit_2d_unit #(
  parameter int COORD_WIDTH  = rbnh_pkg::COORD_WIDTH,
  parameter int ENTITY_WIDTH = rbnh_pkg::ENTITY_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [rbnh_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  wire logic [COORD_WIDTH-1:0]                cfg_wdata,
  rbnh_box_if.sink                                   in_box,
  rbnh_hit_if.source                                 out_hit
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = rbnh_pkg::DIR_WIDTH;
  localparam int NW = CW + rbnh_pkg::DIR_FRAC + 1;

  // Ray registers
  logic signed [CW-1:0] origin_x_r, origin_x_nxt;
  logic signed [CW-1:0] origin_y_r, origin_y_nxt;
  logic        [DW-1:0] dir_x_r,    dir_x_nxt;
  logic        [DW-1:0] dir_y_r,    dir_y_nxt;
  logic        [CW-2:0] ray_len_r,  ray_len_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic                    hit_r,       hit_nxt;
  logic [CW-2:0]           dist_r,      dist_nxt;
  logic [ENTITY_WIDTH-1:0] ent_r,       ent_nxt;

  logic                    slot_free;
  logic                    res_valid;
  logic                    res_hit;
  logic [CW-2:0]           res_distance;
  logic [ENTITY_WIDTH-1:0] res_entity;

  logic                    div_start;
  logic [NW-1:0]           div_num;
  logic [DW-1:0]           div_den;
  logic                    div_neg;
  rbnh_pkg::div_sts_t      div_sts;
  logic signed [CW-1:0]    div_quot;

  // Configuration writes: hold every register unless its index is written
  always_comb begin
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    dir_x_nxt    = dir_x_r;
    dir_y_nxt    = dir_y_r;
    ray_len_nxt  = ray_len_r;
    if (cfg_we) begin
      case (cfg_index)
        rbnh_pkg::CFG_ORIGIN_X:   origin_x_nxt = cfg_wdata;
        rbnh_pkg::CFG_ORIGIN_Y:   origin_y_nxt = cfg_wdata;
        rbnh_pkg::CFG_DIR_X:      dir_x_nxt    = cfg_wdata[DW-1:0];
        rbnh_pkg::CFG_DIR_Y:      dir_y_nxt    = cfg_wdata[DW-1:0];
        rbnh_pkg::CFG_RAY_LENGTH: ray_len_nxt  = cfg_wdata[CW-2:0];
        default: begin
          // unused indexes are dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      dir_x_r    <= rbnh_pkg::DIR_X_RST;
      dir_y_r    <= rbnh_pkg::DIR_Y_RST;
      ray_len_r  <= rbnh_pkg::RAY_LEN_RST[CW-2:0];
    end else begin
      origin_x_r <= origin_x_nxt;
      origin_y_r <= origin_y_nxt;
      dir_x_r    <= dir_x_nxt;
      dir_y_r    <= dir_y_nxt;
      ray_len_r  <= ray_len_nxt;
    end
  end

  // Shared divider for all slab distances
  rbnh_div #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (div_num),
    .den_mag (div_den),
    .neg     (div_neg),
    .sts     (div_sts),
    .quot    (div_quot)
  );

  // Per-box sequencer and running best
  rbnh_seq #(
    .COORD_WIDTH  (COORD_WIDTH),
    .ENTITY_WIDTH (ENTITY_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_box.valid),
    .in_ready     (in_box.ready),
    .box_min_x    (in_box.box_min_x),
    .box_min_y    (in_box.box_min_y),
    .box_max_x    (in_box.box_max_x),
    .box_max_y    (in_box.box_max_y),
    .entity_id    (in_box.entity_id),
    .last_box     (in_box.last_box),
    .origin_x     (origin_x_r),
    .origin_y     (origin_y_r),
    .dir_x        (dir_x_r),
    .dir_y        (dir_y_r),
    .ray_length   (ray_len_r),
    .slot_free    (slot_free),
    .res_valid    (res_valid),
    .res_hit      (res_hit),
    .res_distance (res_distance),
    .res_entity   (res_entity),
    .div_start    (div_start),
    .div_num      (div_num),
    .div_den      (div_den),
    .div_neg      (div_neg),
    .div_sts      (div_sts),
    .div_quot     (div_quot)
  );

  // Output register: load a new result only when the previous one is gone or
  // leaves in this cycle
  assign slot_free = !out_valid_r || out_hit.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    hit_nxt       = hit_r;
    dist_nxt      = dist_r;
    ent_nxt       = ent_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      hit_nxt       = res_hit;
      dist_nxt      = res_distance;
      ent_nxt       = res_entity;
    end else if (out_hit.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= hit_nxt;
    dist_r <= dist_nxt;
    ent_r  <= ent_nxt;
  end

  assign out_hit.valid        = out_valid_r;
  assign out_hit.hit          = hit_r;
  assign out_hit.hit_distance = dist_r;
  assign out_hit.hit_entity   = ent_r;

  // A box transfer always drops ready in the following cycle
  `RBNH_ASSERT_NEXT(a_box_xfer_drops_ready, clk, rst_n, in_box.valid && in_box.ready, !in_box.ready, "ready stayed high after a box transfer")
  // A result never overwrites one that the sink has not taken
  `RBNH_ASSERT(a_result_needs_slot, clk, rst_n, res_valid |-> (!out_valid_r || out_hit.ready), "result loaded over a pending result")
  // A result is produced only while no box is being taken
  `RBNH_ASSERT(a_emit_while_busy, clk, rst_n, res_valid |-> !in_box.ready, "result emitted while accepting a box")
  // A miss always reports the empty entity
  `RBNH_ASSERT(a_miss_entity, clk, rst_n, (out_hit.valid && !out_hit.hit) |-> (&out_hit.hit_entity), "miss reported with an entity")

endmodule

`default_nettype wire

// ===== verif/tb_ray_box_nearest_hit_2d_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ray_box_nearest_hit_2d_unit.
// Depends on rbnh_pkg, rbnh_box_if, rbnh_hit_if and the unit itself; needs no files.
`default_nettype none

module tb_ray_box_nearest_hit_2d_unit;
  import rbnh_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int EW = ENTITY_WIDTH;
  // Worst-case box occupancy (four serial quotients) plus margin.
  localparam int BOX_LATENCY   = 4 * CW + 9 + 16;
  localparam int HOLD_CYCLES   = 600;
  localparam int NUM_STEPS     = 17;
  localparam int NUM_PHASES    = 13;
  localparam int PHASE_BOXES   = 39;
  localparam int IDLE_PERCENT  = 24;
  localparam logic [EW-1:0] NO_ENTITY = '1;

  typedef struct packed {
    logic signed [CW-1:0] min_x;
    logic signed [CW-1:0] min_y;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] max_y;
    logic        [EW-1:0] entity;
    logic                 last;
  } box_t;

  typedef struct packed {
    logic          hit;
    logic [CW-2:0] distance;
    logic [EW-1:0] entity;
  } hit_result_t;

  // One row of the directed table: a box and, where it is obvious, the result it closes.
  typedef struct packed {
    box_t        box;
    logic        pinned;
    hit_result_t want;
  } box_row_t;

  localparam hit_result_t RESET_MISS = {1'b0, 23'd128000, NO_ENTITY};

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [CW-1:0] cfg_wdata;

  rbnh_box_if box_ch ();
  rbnh_hit_if hit_ch ();

  ray_box_nearest_hit_2d_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_box    (box_ch),
    .out_hit   (hit_ch)
  );

  // Ray registers as the unit should hold them.
  logic signed [CW-1:0]        ray_org_x;
  logic signed [CW-1:0]        ray_org_y;
  logic signed [DIR_WIDTH-1:0] ray_dir_x;
  logic signed [DIR_WIDTH-1:0] ray_dir_y;
  logic        [CW-2:0]        ray_len;

  // Running nearest hit of the open stream.
  logic [CW-2:0] best_dist;
  logic [EW-1:0] best_entity;
  logic          seen_hit;

  hit_result_t pending_hits[$];
  int          mismatches;

  // Directed rows may pin the result they close; the predictor still tracks state.
  logic        pin_next;
  hit_result_t pin_want;

  // No idling on either side while calm is set.
  logic calm;
  int   holds_asked;
  int   holds_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Global limit: many times the slowest legal run.
  initial begin
    #5_000_000;
    $display("ray_box_nearest_hit_2d_unit verification failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // Distance along the ray to a slab bound: truncate toward zero, then saturate.
  function automatic longint slab_distance(input longint offset, input longint dir);
    longint q;
    q = (offset * (longint'(1) << DIR_FRAC)) / dir;
    if (q > (longint'(1) << (CW - 1)) - 1) q = (longint'(1) << (CW - 1)) - 1;
    if (q < -(longint'(1) << (CW - 1))) q = -(longint'(1) << (CW - 1));
    return q;
  endfunction

  // Narrow the entry/exit interval on one axis; report whether it is still open.
  function automatic bit slab_overlap(input longint org, input longint dir,
                                      input longint lo, input longint hi,
                                      inout longint t_enter, inout longint t_exit);
    longint t1;
    longint t2;
    longint swap;
    // A zero direction component never crosses the slab: the origin must sit inside it.
    if (dir == 0) return !(org < lo || org > hi);
    t1 = slab_distance(lo - org, dir);
    t2 = slab_distance(hi - org, dir);
    if (t1 > t2) begin
      swap = t1;
      t1   = t2;
      t2   = swap;
    end
    if (t1 > t_enter) t_enter = t1;
    if (t2 < t_exit) t_exit = t2;
    return t_enter <= t_exit;
  endfunction

  // Fold one box into the running best; return 1 with the result when the box closes
  // the stream.
  function automatic bit track_nearest(input box_t b, output hit_result_t r);
    longint t_enter;
    longint t_exit;
    longint reach;
    bit     crossed;
    t_enter = 0;
    t_exit  = longint'(ray_len);
    r       = '0;
    crossed = slab_overlap(longint'(ray_org_x), longint'(ray_dir_x),
                           longint'($signed(b.min_x)), longint'($signed(b.max_x)),
                           t_enter, t_exit) &&
              slab_overlap(longint'(ray_org_y), longint'(ray_dir_y),
                           longint'($signed(b.min_y)), longint'($signed(b.max_y)),
                           t_enter, t_exit);
    if (crossed) begin
      // Before the first hit, compare against the ray length as it is now.
      reach = seen_hit ? longint'(best_dist) : longint'(ray_len);
      // Ties keep the earlier box.
      if (t_enter < reach) begin
        best_dist   = t_enter[CW-2:0];
        best_entity = b.entity;
        seen_hit    = 1'b1;
      end
    end
    if (!b.last) return 1'b0;
    r.hit      = seen_hit;
    r.distance = seen_hit ? best_dist : ray_len;
    r.entity   = seen_hit ? best_entity : NO_ENTITY;
    best_dist   = ray_len;
    best_entity = NO_ENTITY;
    seen_hit    = 1'b0;
    return 1'b1;
  endfunction

  // -------------------------------------------------------------------------
  // Scoreboard: sample both channels and the write port at the rising edge
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    box_t        taken;
    hit_result_t predicted;
    hit_result_t want;
    if (!rst_n) begin
      ray_org_x   = '0;
      ray_org_y   = '0;
      ray_dir_x   = DIR_X_RST;
      ray_dir_y   = DIR_Y_RST;
      ray_len     = RAY_LEN_RST[CW-2:0];
      best_dist   = RAY_LEN_RST[CW-2:0];
      best_entity = NO_ENTITY;
      seen_hit    = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ORIGIN_X:   ray_org_x = cfg_wdata;
          CFG_ORIGIN_Y:   ray_org_y = cfg_wdata;
          CFG_DIR_X:      ray_dir_x = cfg_wdata[DIR_WIDTH-1:0];
          CFG_DIR_Y:      ray_dir_y = cfg_wdata[DIR_WIDTH-1:0];
          CFG_RAY_LENGTH: ray_len   = cfg_wdata[CW-2:0];
          default: ;
        endcase
      end

      // Check a result transfer against the oldest expectation.
      if (hit_ch.valid && hit_ch.ready) begin
        if (pending_hits.size() == 0) begin
          $error("unexpected result: hit=%0d hit_distance=%0d hit_entity=%0d",
                 hit_ch.hit, hit_ch.hit_distance, hit_ch.hit_entity);
          mismatches++;
        end else begin
          want = pending_hits.pop_front();
          if (hit_ch.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit_ch.hit);
            mismatches++;
          end
          if (hit_ch.hit_distance !== want.distance) begin
            $error("hit_distance: expected %0d, got %0d", want.distance,
                   hit_ch.hit_distance);
            mismatches++;
          end
          if (hit_ch.hit_entity !== want.entity) begin
            $error("hit_entity: expected %0d, got %0d", want.entity, hit_ch.hit_entity);
            mismatches++;
          end
        end
      end

      // Predict on every box transfer.
      if (box_ch.valid && box_ch.ready) begin
        taken.min_x  = box_ch.box_min_x;
        taken.min_y  = box_ch.box_min_y;
        taken.max_x  = box_ch.box_max_x;
        taken.max_y  = box_ch.box_max_y;
        taken.entity = box_ch.entity_id;
        taken.last   = box_ch.last_box;
        if (track_nearest(taken, predicted))
          pending_hits.push_back(pin_next ? pin_want : predicted);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result sink: random back-pressure, long hold-offs on request
  // -------------------------------------------------------------------------
  initial begin : result_sink
    hit_ch.ready = 1'b0;
    holds_done   = 0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        // Hold ready low long enough for the unit to back up into its input.
        hit_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      hit_ch.ready = calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  function automatic logic signed [CW-1:0] to_coord(input longint v);
    if (v > (longint'(1) << (CW - 1)) - 1) v = (longint'(1) << (CW - 1)) - 1;
    if (v < -(longint'(1) << (CW - 1))) v = -(longint'(1) << (CW - 1));
    return v[CW-1:0];
  endfunction

  function automatic box_row_t table_row(input longint mnx, input longint mny,
                                         input longint mxx, input longint mxy,
                                         input int ent, input bit lst,
                                         input bit pin, input hit_result_t want);
    box_row_t row;
    row.box.min_x  = to_coord(mnx);
    row.box.min_y  = to_coord(mny);
    row.box.max_x  = to_coord(mxx);
    row.box.max_y  = to_coord(mxy);
    row.box.entity = ent[EW-1:0];
    row.box.last   = lst;
    row.pinned     = pin;
    row.want       = want;
    return row;
  endfunction

  // Mostly boxes placed along the current ray so hits and near misses dominate;
  // the rest are raw bit patterns, inverted boxes among them.
  function automatic box_t random_box(input bit lst);
    box_t   b;
    longint t;
    longint px;
    longint py;
    longint span;
    longint hw;
    longint hh;
    longint cx;
    longint cy;
    b.entity = EW'($urandom_range(0, (1 << EW) - 2));
    b.last   = lst;
    if ($urandom_range(99) < 15) begin
      b.min_x = CW'($urandom);
      b.min_y = CW'($urandom);
      b.max_x = CW'($urandom);
      b.max_y = CW'($urandom);
      return b;
    end
    t    = longint'($urandom_range(0, int'(ray_len) + int'(ray_len) / 4 + 16));
    px   = longint'(ray_org_x) + (t * longint'(ray_dir_x)) / (longint'(1) << DIR_FRAC);
    py   = longint'(ray_org_y) + (t * longint'(ray_dir_y)) / (longint'(1) << DIR_FRAC);
    span = longint'(ray_len) / 8 + 64;
    if (span > (longint'(1) << 20)) span = longint'(1) << 20;
    hw = longint'($urandom_range(0, int'(span)));
    hh = longint'($urandom_range(0, int'(span)));
    cx = px + longint'($urandom_range(0, int'(2 * hw))) - hw;
    cy = py + longint'($urandom_range(0, int'(2 * hh))) - hh;
    b.min_x = to_coord(cx - hw);
    b.max_x = to_coord(cx + hw);
    b.min_y = to_coord(cy - hh);
    b.max_y = to_coord(cy + hh);
    if ($urandom_range(99) < 8) begin
      b.min_x = to_coord(cx + hw);
      b.max_x = to_coord(cx - hw);
    end
    return b;
  endfunction

  // Offer one box; idle between boxes, never drop valid before the transfer.
  task automatic send_box(input box_t b, input logic pin, input hit_result_t want);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      box_ch.valid = 1'b0;
      @(negedge clk);
    end
    pin_next         = pin;
    pin_want         = want;
    box_ch.box_min_x = b.min_x;
    box_ch.box_min_y = b.min_y;
    box_ch.box_max_x = b.max_x;
    box_ch.box_max_y = b.max_y;
    box_ch.entity_id = b.entity;
    box_ch.last_box  = b.last;
    box_ch.valid     = 1'b1;
    do @(posedge clk); while (!box_ch.ready);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input longint value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[CW-1:0];
    @(posedge clk);
  endtask

  task automatic apply_ray(input longint ox, input longint oy, input longint dx,
                           input longint dy, input longint len);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_RAY_LENGTH, len);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Stop offering and wait out every expected result; with a stream still open the
  // unit may be busy on a box that yields nothing, so also let it finish.
  task automatic drain(input bit stream_open);
    @(negedge clk);
    box_ch.valid = 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    if (stream_open) repeat (BOX_LATENCY) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    box_row_t plan [NUM_STEPS];
    int       i;
    int       ph;
    int       sent;
    int       k;
    int       n;
    bit       lst;
    bit       cut;
    bit       stream_open;
    longint   rox;
    longint   roy;
    longint   rdx;
    longint   rdy;
    longint   rlen;

    mismatches       = 0;
    holds_asked      = 0;
    calm             = 1'b0;
    pin_next         = 1'b0;
    pin_want         = '0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_ORIGIN_X;
    cfg_wdata        = '0;
    box_ch.valid     = 1'b0;
    box_ch.box_min_x = '0;
    box_ch.box_min_y = '0;
    box_ch.box_max_x = '0;
    box_ch.box_max_y = '0;
    box_ch.entity_id = '0;
    box_ch.last_box  = 1'b0;
    stream_open      = 1'b0;

    // Directed table, run on the reset ray: origin 0, +X direction, length 500.0.
    // Pinned results read straight off the slab geometry; the rest go through the
    // predictor.
    plan[0]  = table_row(256, -256, 512, 256, 5, 1, 1, {1'b1, 23'd256, 16'd5});
    // behind the origin
    plan[1]  = table_row(-1024, -256, -512, 256, 6, 1, 1, RESET_MISS);
    // zero Y direction, origin below the Y slab, then above it
    plan[2]  = table_row(256, 256, 512, 512, 7, 1, 1, RESET_MISS);
    plan[3]  = table_row(256, -512, 512, -256, 8, 1, 1, RESET_MISS);
    // inverted on the zero-direction axis: miss
    plan[4]  = table_row(256, 256, 512, -256, 9, 1, 1, RESET_MISS);
    // inverted on the moving axis: bounds swap, still a hit
    plan[5]  = table_row(512, -256, 256, 256, 10, 1, 0, '0);
    // three-box stream ending on a tie with the best: the earlier box stays
    plan[6]  = table_row(1024, -256, 2048, 256, 11, 0, 0, '0);
    plan[7]  = table_row(512, -256, 600, 256, 12, 0, 0, '0);
    plan[8]  = table_row(512, -256, 700, 256, 13, 1, 1, {1'b1, 23'd512, 16'd12});
    // all-ones entity is recorded like any other
    plan[9]  = table_row(768, -256, 1024, 256, 16'hFFFF, 1, 1, {1'b1, 23'd768, NO_ENTITY});
    // beyond the ray length, and entering exactly at it (tie with the length)
    plan[10] = table_row(200000, -256, 210000, 256, 14, 1, 1, RESET_MISS);
    plan[11] = table_row(128000, -256, 130000, 256, 15, 1, 1, RESET_MISS);
    // origin inside the box: entry at zero
    plan[12] = table_row(-256, -256, 256, 256, 16, 1, 1, {1'b1, 23'd0, 16'd16});
    // coordinate extremes
    plan[13] = table_row(-8388608, -8388608, 8388607, 8388607, 0, 0, 0, '0);
    plan[14] = table_row(8388607, -8388608, 8388607, 8388607, 65534, 1, 1,
                         {1'b1, 23'd0, 16'd0});
    plan[15] = table_row(-8388608, -8388608, -8388608, -8388608, 1, 1, 1, RESET_MISS);
    plan[16] = table_row(0, 8388607, 0, -8388608, 2, 1, 0, '0);

    // Hold reset, then release it on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < NUM_STEPS; i++)
      send_box(plan[i].box, plan[i].pinned, plan[i].want);
    drain(1'b0);

    // Random phases: each programs a ray, then streams boxes. Some phases stop with a
    // stream still open so the next ray applies mid-stream.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      calm = (ph == 6);
      case (ph)
        0: begin
          rox = -8388608; roy = -8388608; rdx = 16384;  rdy = 16384;  rlen = 8388607;
        end
        1: begin
          rox = 8388607;  roy = 8388607;  rdx = -16384; rdy = -16384; rlen = 8388607;
        end
        2: begin
          rox = 0;        roy = 0;        rdx = 0;      rdy = -16384; rlen = 0;
        end
        3: begin
          rox = -1000;    roy = 500;      rdx = 11585;  rdy = 11585;  rlen = 128000;
        end
        4: begin
          // tiny direction: quotients saturate
          rox = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
          roy = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
          rdx = 1; rdy = -1; rlen = 8388607;
        end
        default: begin
          if ($urandom_range(99) < 20) begin
            rox = longint'($urandom_range(0, (1 << CW) - 1)) - (1 << (CW - 1));
            roy = longint'($urandom_range(0, (1 << CW) - 1)) - (1 << (CW - 1));
          end else begin
            rox = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            roy = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
          end
          rdx = ($urandom_range(99) < 15) ? 0 : longint'($urandom_range(0, 32768)) - 16384;
          rdy = ($urandom_range(99) < 15) ? 0 : longint'($urandom_range(0, 32768)) - 16384;
          rlen = ($urandom_range(99) < 80) ? longint'($urandom_range(0, 1 << 20))
                                           : longint'($urandom_range(0, 8388607));
        end
      endcase
      apply_ray(rox, roy, rdx, rdy, rlen);

      // Starve the result side while boxes keep coming.
      if (ph == 3) holds_asked++;

      sent = 0;
      while (sent < PHASE_BOXES) begin
        n   = (ph == 3) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        cut = (ph % 4 == 1) && (sent + n >= PHASE_BOXES);
        for (k = 0; k < n; k++) begin
          lst = (k == n - 1) && !cut;
          send_box(random_box(lst), 1'b0, '0);
          stream_open = !lst;
        end
        sent += n;
      end
      drain(stream_open);
    end

    // Let any straggler surface before the verdict.
    repeat (BOX_LATENCY) @(posedge clk);
    if (pending_hits.size() != 0) begin
      $error("%0d expected results never arrived", pending_hits.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("ray_box_nearest_hit_2d_unit verification clean");
    else
      $display("ray_box_nearest_hit_2d_unit verification failed");
    $finish;
  end

endmodule

`default_nettype wire
